// ===== sv/md5_message_digest_defines.svh =====
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// same-cycle implication
`define MD5_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("md5 check failed");

// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("md5 check failed");

`endif

// ===== sv/md5_pkg.sv =====
package md5_pkg;

   localparam int WORD_W       = 32;
   localparam int COUNT_W      = 3;
   localparam int BLOCK_WORDS  = 16;
   localparam int WIDX_W       = 4;
   localparam int FILL_W       = 6;
   localparam int LEN_W        = 61;
   localparam int ROUND_W      = 6;
   localparam int ROT_W        = 5;
   localparam int DIGEST_WORDS = 4;
   localparam int DIDX_W       = 2;

   localparam logic [COUNT_W-1:0] WORD_BYTES  = 3'd4;
   localparam logic [7:0]         PAD_BYTE    = 8'h80;
   localparam logic [ROUND_W-1:0] ROUND_LAST  = 6'd63;
   localparam logic [DIDX_W-1:0]  DIGEST_LAST = 2'd3;
   localparam logic [WIDX_W-1:0]  LEN_LO_IDX  = 4'd14;
   localparam logic [WIDX_W-1:0]  LEN_HI_IDX  = 4'd15;

   localparam logic [1:0] GRP_F = 2'd0;
   localparam logic [1:0] GRP_G = 2'd1;
   localparam logic [1:0] GRP_H = 2'd2;
   localparam logic [1:0] GRP_I = 2'd3;

   localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
   localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LENGTH,
      ST_LOAD,
      ST_ROUNDS,
      ST_FOLD,
      ST_EMIT
   } md5_state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_PAD,
      PH_FINAL
   } md5_phase_type;

   typedef struct packed {
      logic              load_word;
      logic              pad;
      logic              clear;
      logic              length;
      logic              start;
      logic              round;
      logic              fold;
      logic              restart;
      logic [DIDX_W-1:0] emit_index;
   } md5_cmd_type;

   typedef struct packed {
      logic block_full;
      logic pad_two;
      logic round_last;
   } md5_status_type;

   function automatic logic [WORD_W-1:0] md5_round_add(input logic [ROUND_W-1:0] r);
      case (r)
         6'd0:  return 32'hd76aa478;
         6'd1:  return 32'he8c7b756;
         6'd2:  return 32'h242070db;
         6'd3:  return 32'hc1bdceee;
         6'd4:  return 32'hf57c0faf;
         6'd5:  return 32'h4787c62a;
         6'd6:  return 32'ha8304613;
         6'd7:  return 32'hfd469501;
         6'd8:  return 32'h698098d8;
         6'd9:  return 32'h8b44f7af;
         6'd10: return 32'hffff5bb1;
         6'd11: return 32'h895cd7be;
         6'd12: return 32'h6b901122;
         6'd13: return 32'hfd987193;
         6'd14: return 32'ha679438e;
         6'd15: return 32'h49b40821;
         6'd16: return 32'hf61e2562;
         6'd17: return 32'hc040b340;
         6'd18: return 32'h265e5a51;
         6'd19: return 32'he9b6c7aa;
         6'd20: return 32'hd62f105d;
         6'd21: return 32'h02441453;
         6'd22: return 32'hd8a1e681;
         6'd23: return 32'he7d3fbc8;
         6'd24: return 32'h21e1cde6;
         6'd25: return 32'hc33707d6;
         6'd26: return 32'hf4d50d87;
         6'd27: return 32'h455a14ed;
         6'd28: return 32'ha9e3e905;
         6'd29: return 32'hfcefa3f8;
         6'd30: return 32'h676f02d9;
         6'd31: return 32'h8d2a4c8a;
         6'd32: return 32'hfffa3942;
         6'd33: return 32'h8771f681;
         6'd34: return 32'h6d9d6122;
         6'd35: return 32'hfde5380c;
         6'd36: return 32'ha4beea44;
         6'd37: return 32'h4bdecfa9;
         6'd38: return 32'hf6bb4b60;
         6'd39: return 32'hbebfbc70;
         6'd40: return 32'h289b7ec6;
         6'd41: return 32'heaa127fa;
         6'd42: return 32'hd4ef3085;
         6'd43: return 32'h04881d05;
         6'd44: return 32'hd9d4d039;
         6'd45: return 32'he6db99e5;
         6'd46: return 32'h1fa27cf8;
         6'd47: return 32'hc4ac5665;
         6'd48: return 32'hf4292244;
         6'd49: return 32'h432aff97;
         6'd50: return 32'hab9423a7;
         6'd51: return 32'hfc93a039;
         6'd52: return 32'h655b59c3;
         6'd53: return 32'h8f0ccc92;
         6'd54: return 32'hffeff47d;
         6'd55: return 32'h85845dd1;
         6'd56: return 32'h6fa87e4f;
         6'd57: return 32'hfe2ce6e0;
         6'd58: return 32'ha3014314;
         6'd59: return 32'h4e0811a1;
         6'd60: return 32'hf7537e82;
         6'd61: return 32'hbd3af235;
         6'd62: return 32'h2ad7d2bb;
         default: return 32'heb86d391;
      endcase
   endfunction

   function automatic logic [ROT_W-1:0] md5_rot_amount(input logic [ROUND_W-1:0] r);
      case ({r[5:4], r[1:0]})
         4'd0:  return 5'd7;
         4'd1:  return 5'd12;
         4'd2:  return 5'd17;
         4'd3:  return 5'd22;
         4'd4:  return 5'd5;
         4'd5:  return 5'd9;
         4'd6:  return 5'd14;
         4'd7:  return 5'd20;
         4'd8:  return 5'd4;
         4'd9:  return 5'd11;
         4'd10: return 5'd16;
         4'd11: return 5'd23;
         4'd12: return 5'd6;
         4'd13: return 5'd10;
         4'd14: return 5'd15;
         default: return 5'd21;
      endcase
   endfunction

   function automatic logic [WIDX_W-1:0] md5_msg_index(input logic [ROUND_W-1:0] r);
      logic [WIDX_W-1:0] lo;
      lo = r[3:0];
      case (r[5:4])
         GRP_F:   return lo;
         GRP_G:   return 4'((lo << 2) + lo + 4'd1);
         GRP_H:   return 4'((lo << 1) + lo + 4'd5);
         default: return 4'((lo << 3) - lo);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] md5_mix(input logic [1:0] grp,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      case (grp)
         GRP_F:   return (b & c) | (~b & d);
         GRP_G:   return (b & d) | (c & ~d);
         GRP_H:   return b ^ c ^ d;
         default: return c ^ (b | ~d);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] md5_rotl(input logic [WORD_W-1:0] v,
                                                  input logic [ROT_W-1:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ===== sv/md5_req_if.sv =====
interface md5_req_if;
   logic                            valid;
   logic                            ready;
   logic [md5_pkg::WORD_W-1:0]      message_word;
   logic [md5_pkg::COUNT_W-1:0]     valid_bytes;
   logic                            last_item;

   modport source (output valid, message_word, valid_bytes, last_item, input ready);
   modport sink (input valid, message_word, valid_bytes, last_item, output ready);
endinterface

// ===== sv/md5_rsp_if.sv =====
interface md5_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [md5_pkg::WORD_W-1:0]      digest_word;
   logic [md5_pkg::DIDX_W-1:0]      digest_index;
   logic                            digest_done;

   modport source (output valid, digest_word, digest_index, digest_done, input ready);
   modport sink (input valid, digest_word, digest_index, digest_done, output ready);
endinterface

// ===== sv/md5_message_digest.sv =====
// channel  dir  handshake     payload
// req_chan in   valid/ready   message_word[31:0] valid_bytes[2:0] last_item
// rsp_chan out  valid/ready   digest_word[31:0] digest_index[1:0] digest_done
//
// A word that does not close a block is taken in the idle state; a word that fills a block
// adds a block compression (load, 64 rounds of the single round unit, fold).
// The last word adds a pad step and one block, or two when eight or fewer free bytes
// remain, with a length step before the second; then four result items.
// Synchronous reset restores the initial chain value and clears length and fill.
// req_chan is held off outside idle: while padding, while a block is compressed or the digest is out.
module md5_message_digest (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_chan,
   md5_rsp_if.source rsp_chan
);

   md5_pkg::md5_cmd_type    cmd;
   md5_pkg::md5_status_type status;

   md5_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_item),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   md5_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_chan.message_word),
      .valid_bytes  (req_chan.valid_bytes),
      .last_item    (req_chan.last_item),
      .status       (status),
      .digest_word  (rsp_chan.digest_word)
   );

   assign rsp_chan.digest_index = cmd.emit_index;
   assign rsp_chan.digest_done  = (cmd.emit_index == md5_pkg::DIGEST_LAST);

endmodule

// ===== sv/md5_datapath.sv =====
module md5_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  md5_pkg::md5_cmd_type            cmd,
   input  logic [md5_pkg::WORD_W-1:0]      message_word,
   input  logic [md5_pkg::COUNT_W-1:0]     valid_bytes,
   input  logic                            last_item,
   output md5_pkg::md5_status_type         status,
   output logic [md5_pkg::WORD_W-1:0]      digest_word
);

   logic [md5_pkg::WORD_W-1:0]  chain_ff [md5_pkg::DIGEST_WORDS];
   logic [md5_pkg::WORD_W-1:0]  chain_in [md5_pkg::DIGEST_WORDS];
   logic [md5_pkg::WORD_W-1:0]  block_ff [md5_pkg::BLOCK_WORDS];
   logic [md5_pkg::WORD_W-1:0]  block_in [md5_pkg::BLOCK_WORDS];
   logic [md5_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [md5_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [md5_pkg::ROUND_W-1:0] round_ff, round_in;
   logic [md5_pkg::WORD_W-1:0]  wa_ff, wb_ff, wc_ff, wd_ff;
   logic [md5_pkg::WORD_W-1:0]  wa_in, wb_in, wc_in, wd_in;

   logic [md5_pkg::COUNT_W-1:0] count;
   logic [md5_pkg::FILL_W:0]    fill_sum;
   logic [md5_pkg::WORD_W-1:0]  masked_word;
   logic [md5_pkg::WORD_W-1:0]  pad_word;
   logic [md5_pkg::WIDX_W-1:0]  load_idx;
   logic [md5_pkg::WIDX_W-1:0]  pad_idx;
   logic [1:0]                  pad_lane;
   logic [2*md5_pkg::WORD_W-1:0] bit_len;
   logic [md5_pkg::WORD_W-1:0]  round_sum;

   assign count = (!last_item || valid_bytes > md5_pkg::WORD_BYTES)
                  ? md5_pkg::WORD_BYTES : valid_bytes;
   assign fill_sum = {1'b0, fill_ff} + (md5_pkg::FILL_W+1)'(count);
   assign load_idx = fill_ff[5:2];
   assign pad_idx  = fill_ff[5:2];
   assign pad_lane = fill_ff[1:0];
   assign bit_len  = {len_ff, 3'b000};

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         masked_word[8*j +: 8] = (3'(j) < count) ? message_word[8*j +: 8] : 8'h00;
         if (2'(j) < pad_lane) begin
            pad_word[8*j +: 8] = block_ff[pad_idx][8*j +: 8];
         end else if (2'(j) == pad_lane) begin
            pad_word[8*j +: 8] = md5_pkg::PAD_BYTE;
         end else begin
            pad_word[8*j +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < md5_pkg::BLOCK_WORDS; k++) begin
         block_in[k] = block_ff[k];
         if (cmd.load_word && 4'(k) == load_idx) begin
            block_in[k] = masked_word;
         end
         if (cmd.pad) begin
            if (4'(k) == pad_idx) begin
               block_in[k] = pad_word;
            end else if (4'(k) > pad_idx) begin
               block_in[k] = '0;
            end
         end
         if (cmd.clear) begin
            block_in[k] = '0;
         end
         if (cmd.length && 4'(k) == md5_pkg::LEN_LO_IDX) begin
            block_in[k] = bit_len[md5_pkg::WORD_W-1:0];
         end
         if (cmd.length && 4'(k) == md5_pkg::LEN_HI_IDX) begin
            block_in[k] = bit_len[2*md5_pkg::WORD_W-1:md5_pkg::WORD_W];
         end
      end
   end

   always_comb begin
      round_sum = wa_ff
                + md5_pkg::md5_mix(round_ff[5:4], wb_ff, wc_ff, wd_ff)
                + block_ff[md5_pkg::md5_msg_index(round_ff)]
                + md5_pkg::md5_round_add(round_ff);
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      wc_in    = wc_ff;
      wd_in    = wd_ff;
      round_in = round_ff;
      if (cmd.start) begin
         wa_in    = chain_ff[0];
         wb_in    = chain_ff[1];
         wc_in    = chain_ff[2];
         wd_in    = chain_ff[3];
         round_in = '0;
      end else if (cmd.round) begin
         wa_in    = wd_ff;
         wd_in    = wc_ff;
         wc_in    = wb_ff;
         wb_in    = wb_ff + md5_pkg::md5_rotl(round_sum, md5_pkg::md5_rot_amount(round_ff));
         round_in = round_ff + 6'd1;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      if (cmd.load_word) begin
         fill_in = fill_sum[md5_pkg::FILL_W-1:0];
         len_in  = len_ff + md5_pkg::LEN_W'(count);
      end
      if (cmd.fold) begin
         chain_in[0] = chain_ff[0] + wa_ff;
         chain_in[1] = chain_ff[1] + wb_ff;
         chain_in[2] = chain_ff[2] + wc_ff;
         chain_in[3] = chain_ff[3] + wd_ff;
      end
      if (cmd.restart) begin
         chain_in[0] = md5_pkg::INIT_A;
         chain_in[1] = md5_pkg::INIT_B;
         chain_in[2] = md5_pkg::INIT_C;
         chain_in[3] = md5_pkg::INIT_D;
         fill_in     = '0;
         len_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= md5_pkg::INIT_A;
         chain_ff[1] <= md5_pkg::INIT_B;
         chain_ff[2] <= md5_pkg::INIT_C;
         chain_ff[3] <= md5_pkg::INIT_D;
         fill_ff     <= '0;
         len_ff      <= '0;
         round_ff    <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      wc_ff    <= wc_in;
      wd_ff    <= wd_in;
   end

   assign status.block_full = fill_sum[md5_pkg::FILL_W];
   assign status.pad_two    = (fill_ff[5:3] == 3'b111);
   assign status.round_last = (round_ff == md5_pkg::ROUND_LAST);
   assign digest_word       = chain_ff[cmd.emit_index];

endmodule

// ===== sv/md5_control.sv =====
`include "md5_message_digest_defines.svh"

module md5_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  md5_pkg::md5_status_type  status,
   output md5_pkg::md5_cmd_type     cmd
);

   md5_pkg::md5_state_type      state_ff, state_in;
   md5_pkg::md5_phase_type      phase_ff, phase_in;
   logic                        last_ff, last_in;
   logic [md5_pkg::DIDX_W-1:0]  emit_ff, emit_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      emit_in  = emit_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               if (status.block_full) begin
                  phase_in = md5_pkg::PH_DATA;
                  state_in = md5_pkg::ST_LOAD;
               end else if (req_last) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            phase_in = status.pad_two ? md5_pkg::PH_PAD : md5_pkg::PH_FINAL;
            state_in = md5_pkg::ST_LOAD;
         end
         md5_pkg::ST_LENGTH: begin
            phase_in = md5_pkg::PH_FINAL;
            state_in = md5_pkg::ST_LOAD;
         end
         md5_pkg::ST_LOAD: begin
            state_in = md5_pkg::ST_ROUNDS;
         end
         md5_pkg::ST_ROUNDS: begin
            if (status.round_last) begin
               state_in = md5_pkg::ST_FOLD;
            end
         end
         md5_pkg::ST_FOLD: begin
            case (phase_ff)
               md5_pkg::PH_DATA:  state_in = last_ff ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
               md5_pkg::PH_PAD:   state_in = md5_pkg::ST_LENGTH;
               default: begin
                  emit_in  = '0;
                  state_in = md5_pkg::ST_EMIT;
               end
            endcase
         end
         md5_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               if (emit_ff == md5_pkg::DIGEST_LAST) begin
                  last_in  = 1'b0;
                  state_in = md5_pkg::ST_IDLE;
               end else begin
                  emit_in = emit_ff + 2'd1;
               end
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.emit_index = emit_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_word = req_valid;
         end
         md5_pkg::ST_PAD: begin
            cmd.pad    = 1'b1;
            cmd.length = !status.pad_two;
         end
         md5_pkg::ST_LENGTH: begin
            cmd.clear  = 1'b1;
            cmd.length = 1'b1;
         end
         md5_pkg::ST_LOAD:   cmd.start = 1'b1;
         md5_pkg::ST_ROUNDS: cmd.round = 1'b1;
         md5_pkg::ST_FOLD:   cmd.fold  = 1'b1;
         md5_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.restart = rsp_ready && (emit_ff == md5_pkg::DIGEST_LAST);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         phase_ff <= md5_pkg::PH_DATA;
         last_ff  <= 1'b0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         emit_ff  <= emit_in;
      end
   end

   `MD5_ASSERT_IMPLY(emit_after_final, clock, reset, (state_ff == md5_pkg::ST_EMIT), (phase_ff == md5_pkg::PH_FINAL))
   `MD5_ASSERT_NEXT(single_pad_is_final, clock, reset, (state_ff == md5_pkg::ST_PAD && !status.pad_two), (phase_ff == md5_pkg::PH_FINAL && state_ff == md5_pkg::ST_LOAD))
   `MD5_ASSERT_NEXT(done_returns_idle, clock, reset, (rsp_valid && rsp_ready && emit_ff == md5_pkg::DIGEST_LAST), (state_ff == md5_pkg::ST_IDLE && !last_ff))

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [md5_pkg::WORD_W-1:0]  word;
      logic [md5_pkg::COUNT_W-1:0] nbytes;
      logic                        last;
      logic                        drain;
   } msg_word_type;

   typedef struct packed {
      logic [md5_pkg::WORD_W-1:0] word;
      logic [md5_pkg::DIDX_W-1:0] index;
      logic                       done;
   } digest_type;

   localparam logic [md5_pkg::WORD_W-1:0] SINE_TERM [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_TABLE [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   logic clock;
   logic reset = 1'b1;

   md5_req_if req_chan ();
   md5_rsp_if rsp_chan ();

   md5_message_digest dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [md5_pkg::WORD_W-1:0] chain [4];
   logic [md5_pkg::WORD_W-1:0] block_buf [16];
   int unsigned                fill_count;
   logic [md5_pkg::LEN_W-1:0]  byte_total;

   msg_word_type word_q [$];
   digest_type   digest_q [$];

   int   errors = 0;
   int   req_count = 0;
   logic req_fired = 1'b0;
   logic calm;

   assign calm = (req_count >= 100) && (req_count < 140);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic restart_digest();
      chain[0]   = md5_pkg::INIT_A;
      chain[1]   = md5_pkg::INIT_B;
      chain[2]   = md5_pkg::INIT_C;
      chain[3]   = md5_pkg::INIT_D;
      fill_count = 0;
      byte_total = '0;
      for (int k = 0; k < 16; k++) block_buf[k] = '0;
   endtask

   task automatic fold_block();
      logic [md5_pkg::WORD_W-1:0] a, b, c, d, f, t;
      int g, grp, rot;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         grp = r / 16;
         case (grp)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t   = a + f + block_buf[g] + SINE_TERM[r];
         rot = ROT_TABLE[grp * 4 + r % 4];
         a   = d;
         d   = c;
         c   = b;
         b   = b + ((t << rot) | (t >> (32 - rot)));
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
   endtask

   task automatic take_word(input logic [md5_pkg::WORD_W-1:0] w,
                            input logic [md5_pkg::COUNT_W-1:0] nb, input logic last);
      logic [md5_pkg::COUNT_W-1:0] cnt;
      logic [md5_pkg::WORD_W-1:0]  data;
      logic [63:0]                 bits;
      digest_type                  d;
      int                          slot, sh;
      cnt  = (!last || nb > md5_pkg::WORD_BYTES) ? md5_pkg::WORD_BYTES : nb;
      data = w;
      if (cnt < md5_pkg::WORD_BYTES) data = data & ((32'd1 << (8 * cnt)) - 32'd1);
      slot = fill_count / 4;
      block_buf[slot] = data;
      fill_count = fill_count + cnt;
      byte_total = byte_total + md5_pkg::LEN_W'(cnt);
      if (fill_count >= 64) begin
         fold_block();
         fill_count = 0;
      end
      if (last) begin
         slot = fill_count / 4;
         sh   = (fill_count % 4) * 8;
         if (sh == 0) block_buf[slot] = '0;
         block_buf[slot] = block_buf[slot] | (md5_pkg::WORD_W'(md5_pkg::PAD_BYTE) << sh);
         for (int k = slot + 1; k < 16; k++) block_buf[k] = '0;
         if (fill_count >= 56) begin
            fold_block();
            for (int k = 0; k < 16; k++) block_buf[k] = '0;
         end
         bits = {byte_total, 3'b000};
         block_buf[md5_pkg::LEN_LO_IDX] = bits[31:0];
         block_buf[md5_pkg::LEN_HI_IDX] = bits[63:32];
         fold_block();
         for (int k = 0; k < md5_pkg::DIGEST_WORDS; k++) begin
            d.word  = chain[k];
            d.index = md5_pkg::DIDX_W'(k);
            d.done  = (md5_pkg::DIDX_W'(k) == md5_pkg::DIGEST_LAST);
            digest_q.push_back(d);
         end
         restart_digest();
      end
   endtask

   task automatic push_word(input logic [md5_pkg::WORD_W-1:0] w,
                            input logic [md5_pkg::COUNT_W-1:0] nb,
                            input logic last, input logic drain);
      msg_word_type m;
      m.word   = w;
      m.nbytes = nb;
      m.last   = last;
      m.drain  = drain;
      word_q.push_back(m);
   endtask

   task automatic queue_message(input int nwords, input logic drain);
      for (int i = 0; i < nwords; i++)
         push_word($urandom(), md5_pkg::COUNT_W'($urandom_range(0, 7)), i == nwords - 1,
                   drain && (i == 0));
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         take_word(req_chan.message_word, req_chan.valid_bytes, req_chan.last_item);
         word_q.delete(0);
         req_fired = 1'b1;
         req_count++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         req_fired = 1'b0;
         if (word_q.size() > 0 && !(word_q[0].drain && digest_q.size() > 0) &&
             (calm || $urandom_range(0, 99) >= 15)) begin
            req_chan.valid        <= 1'b1;
            req_chan.message_word <= word_q[0].word;
            req_chan.valid_bytes  <= word_q[0].nbytes;
            req_chan.last_item    <= word_q[0].last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin : check_digest
      digest_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest item, expected none actual %h/%0d/%0d", $time,
                     rsp_chan.digest_word, rsp_chan.digest_index, rsp_chan.digest_done);
            errors++;
         end else begin
            want = digest_q.pop_front();
            if (rsp_chan.digest_word !== want.word) begin
               $display("%0t: digest_word expected %h actual %h", $time, want.word,
                        rsp_chan.digest_word);
               errors++;
            end
            if (rsp_chan.digest_index !== want.index) begin
               $display("%0t: digest_index expected %0d actual %0d", $time, want.index,
                        rsp_chan.digest_index);
               errors++;
            end
            if (rsp_chan.digest_done !== want.done) begin
               $display("%0t: digest_done expected %0d actual %0d", $time, want.done,
                        rsp_chan.digest_done);
               errors++;
            end
         end
      end
   end

   initial begin
      int random_words;
      int pick, nwords;
      req_chan.valid        = 1'b0;
      req_chan.message_word = '0;
      req_chan.valid_bytes  = '0;
      req_chan.last_item    = 1'b0;
      rsp_chan.ready        = 1'b0;
      restart_digest();

      for (int n = 0; n < 8; n++)
         push_word((n % 3 == 0) ? '1 : (n % 3 == 1) ? '0 : $urandom(),
                   md5_pkg::COUNT_W'(n), 1'b1, 1'b0);
      for (int i = 0; i < 16; i++)
         push_word($urandom(),
                   (i == 15) ? md5_pkg::WORD_BYTES : md5_pkg::COUNT_W'($urandom_range(0, 7)),
                   i == 15, 1'b0);

      random_words = 0;
      while (random_words < 156) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) nwords = $urandom_range(1, 4);
         else if (pick < 8) nwords = $urandom_range(13, 17);
         else nwords = $urandom_range(18, 34);
         queue_message(nwords, (random_words == 0) || ($urandom_range(0, 4) == 0));
         random_words += nwords;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (word_q.size() != 0 || digest_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
